// ===== rtl/ohm_pkg.sv =====
// ohm_pkg: word layouts, command codes and register reset values for the
// operating hour meter; no dependencies, imported by operating_hour_meter_core
package ohm_pkg;

    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // command codes carried in s_tuser
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLUSH_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_LENGTH    = 2'd2;

    // register reset values
    localparam logic [7:0]  FLUSH_LIMIT_RST    = 8'd240;
    localparam logic [23:0] CHECK_INTERVAL_RST = 24'd60000;
    localparam logic [23:0] HOUR_LENGTH_RST    = 24'd3600000;

    // counter ceilings
    localparam logic [24:0] BASE_MAX  = 25'h1FF_FFFF;
    localparam logic [23:0] CHECK_MAX = 24'hFF_FFFF;
    localparam logic [7:0]  PEND_MAX  = 8'd255;

    // input word, last field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic        rtc_time_valid;
        logic [7:0]  rtc_ram_value;
        logic        rtc_ram_ok;
        logic        rtc_present;
        logic        store_ok;
        logic [31:0] stored_starts;
        logic [31:0] stored_total;
    } in_word_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic        store_starts_write;
        logic        store_total_write;
        logic [7:0]  ram_value;
        logic        ram_write;
        logic        attached;
        logic [31:0] start_count;
        logic [7:0]  pending_hours;
        logic [31:0] total_hours;
    } out_word_t;

endpackage

// ===== rtl/operating_hour_meter_core.sv =====
// operating_hour_meter_core: hour meter with backup byte attach and flush logic
// depends on ohm_pkg for word layouts, command codes and reset values
// path: a word accepted into the input register moves through one pass of logic
// into the result register once that register is free or drained
// throughput: one word per cycle while m_tready is high; the meter state
// and result register are written at the same edge, so the next word sees the new state
// reset: aresetn synchronous, active low; clears valid flags, meter state
// and restores the configuration register defaults
module operating_hour_meter_core
    import ohm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: stored_total[31:0], stored_starts[63:32], store_ok[64],
    // rtc_present[65], rtc_ram_ok[66], rtc_ram_value[74:67],
    // rtc_time_valid[75], zero pad[79:76]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [CMD_W-1:0]      s_tuser,

    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: total_hours[31:0], pending_hours[39:32], start_count[71:40],
    // attached[72], ram_write[73], ram_value[81:74], store_total_write[82],
    // store_starts_write[83], zero pad[87:84]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // configuration registers
    logic [7:0]  flush_limit_reg;
    logic [23:0] check_interval_reg;
    logic [23:0] hour_length_reg;

    // meter state
    logic [31:0] total_reg,       total_next;
    logic [7:0]  pending_reg,     pending_next;
    logic [31:0] starts_reg,      starts_next;
    logic        linked_reg,      linked_next;
    logic [24:0] since_base_reg,  since_base_next;
    logic [23:0] since_check_reg, since_check_next;

    // input stage
    logic           in_valid_reg;
    in_word_t       in_word_reg;
    logic [CMD_W-1:0] in_cmd_reg;

    // result stage
    logic           out_valid_reg;
    out_word_t      out_word_reg, out_word_next;

    logic advance;

    // the input stage moves on whenever the result register is free or drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_limit_reg    <= FLUSH_LIMIT_RST;
            check_interval_reg <= CHECK_INTERVAL_RST;
            hour_length_reg    <= HOUR_LENGTH_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FLUSH_LIMIT:    flush_limit_reg    <= cfg_wdata[7:0];
                REG_CHECK_INTERVAL: check_interval_reg <= cfg_wdata;
                REG_HOUR_LENGTH:    hour_length_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= in_word_t'(s_tdata);
            in_cmd_reg  <= s_tuser;
        end
    end

    // one pass of meter logic
    logic [23:0] interval;
    logic [23:0] sc_inc;
    logic [24:0] sb_inc;
    logic        check_due;
    logic        discard;
    logic [7:0]  attach_byte;
    logic [7:0]  pend_inc;

    always_comb begin
        // effective check interval never exceeds the hour length
        interval = (check_interval_reg < hour_length_reg) ? check_interval_reg
                                                          : hour_length_reg;
        sc_inc    = since_check_reg + ((since_check_reg < CHECK_MAX) ? 24'd1 : 24'd0);
        sb_inc    = since_base_reg + ((since_base_reg < BASE_MAX) ? 25'd1 : 25'd0);
        check_due = (sc_inc >= interval);
        discard   = !in_word_reg.rtc_time_valid
                    || (in_word_reg.rtc_ram_value > flush_limit_reg);
        attach_byte = discard ? 8'd0 : in_word_reg.rtc_ram_value;
        pend_inc  = (pending_reg == PEND_MAX) ? PEND_MAX : pending_reg + 8'd1;

        total_next       = total_reg;
        pending_next     = pending_reg;
        starts_next      = starts_reg;
        linked_next      = linked_reg;
        since_base_next  = since_base_reg;
        since_check_next = since_check_reg;

        out_word_next                    = '0;

        case (in_cmd_reg)
            CMD_TICK: begin
                since_check_next = sc_inc;
                since_base_next  = sb_inc;
                if (check_due) begin
                    since_check_next = 24'd0;
                    if (!linked_reg) begin
                        // attach attempt on the backup byte
                        if (in_word_reg.rtc_present && in_word_reg.rtc_ram_ok) begin
                            linked_next     = 1'b1;
                            since_base_next = 25'd0;
                            pending_next    = attach_byte;
                            out_word_next.ram_write = discard;
                            if (attach_byte != 8'd0) begin
                                // immediate flush of the recovered hours
                                total_next   = total_reg + {24'd0, attach_byte};
                                pending_next = 8'd0;
                                out_word_next.store_total_write = in_word_reg.store_ok;
                                out_word_next.ram_write         = 1'b1;
                            end
                        end
                    end else if (sb_inc >= {1'b0, hour_length_reg}) begin
                        // one counted hour per check
                        since_base_next         = sb_inc - {1'b0, hour_length_reg};
                        pending_next            = pend_inc;
                        out_word_next.ram_write = 1'b1;
                        out_word_next.ram_value = pend_inc;
                        if (pend_inc >= flush_limit_reg) begin
                            total_next              = total_reg + {24'd0, pend_inc};
                            pending_next            = 8'd0;
                            out_word_next.ram_value = 8'd0;
                            out_word_next.store_total_write = in_word_reg.store_ok;
                        end
                    end
                end
            end
            CMD_START: begin
                if (in_word_reg.store_ok) begin
                    total_next  = in_word_reg.stored_total;
                    starts_next = in_word_reg.stored_starts + 32'd1;
                    out_word_next.store_starts_write = 1'b1;
                end
                since_base_next  = 25'd0;
                since_check_next = 24'd0;
            end
            CMD_CLEAR: begin
                total_next       = 32'd0;
                pending_next     = 8'd0;
                starts_next      = 32'd0;
                since_base_next  = 25'd0;
                since_check_next = 24'd0;
                out_word_next.store_total_write  = in_word_reg.store_ok;
                out_word_next.store_starts_write = in_word_reg.store_ok;
                out_word_next.ram_write          = linked_reg;
            end
            default: ;  // unused code leaves the meter as is
        endcase

        out_word_next.total_hours   = total_next;
        out_word_next.pending_hours = pending_next;
        out_word_next.start_count   = starts_next;
        out_word_next.attached      = linked_next;
    end

    // meter state, updated as the word moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg       <= 32'd0;
            pending_reg     <= 8'd0;
            starts_reg      <= 32'd0;
            linked_reg      <= 1'b0;
            since_base_reg  <= 25'd0;
            since_check_reg <= 24'd0;
        end else if (advance) begin
            total_reg       <= total_next;
            pending_reg     <= pending_next;
            starts_reg      <= starts_next;
            linked_reg      <= linked_next;
            since_base_reg  <= since_base_next;
            since_check_reg <= since_check_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

    // once attached the meter never detaches
    a_link_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        linked_reg |=> linked_reg)
        else $error("meter detached from backup byte");

    // a held input word is never overwritten
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_word_reg)))
        else $error("input word lost while stalled");

    // backup byte value is zero unless a write is flagged
    a_ram_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_word_reg.ram_write) |-> (out_word_reg.ram_value == 8'd0))
        else $error("backup byte value without write");

    // a total write always follows a flush or clear, leaving nothing pending
    a_total_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_word_reg.store_total_write)
            |-> (out_word_reg.pending_hours == 8'd0))
        else $error("total written with hours still pending");

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for operating_hour_meter_core, one result word per command word
// needs ohm_pkg and operating_hour_meter_core; an in-bench hour meter model predicts every result
module testbench;
    import ohm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // a pending command word: command code plus the input fields
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        in_word_t         payload;
    } meter_item_t;

    // no-accept cycles allowed: covers the long receiver hold plus
    // the worst sender gap and receiver stall around it, several times over
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // words waiting to be offered, and predicted results waiting to arrive
    meter_item_t cmd_backlog[$];
    out_word_t   expected_words[$];

    // per-side idling switches, set per phase
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   rx_hold = 0;
    int   hold_req_seq = 0;
    int   hold_req_seen = 0;
    int   quiet_cycles = 0;
    int   fail_count = 0;

    // hour meter copy: configuration
    logic [7:0]  lim_flush = FLUSH_LIMIT_RST;
    logic [23:0] ivl_check = CHECK_INTERVAL_RST;
    logic [23:0] len_hour  = HOUR_LENGTH_RST;
    // hour meter copy: state
    logic [31:0] hm_total = '0;
    logic [7:0]  hm_pending = '0;
    logic [31:0] hm_starts = '0;
    logic        hm_linked = 1'b0;
    logic [24:0] hm_since_base = '0;
    logic [23:0] hm_since_check = '0;
    // side effects of the word being modeled
    logic        wr_ram, wr_total, wr_starts, cur_store;
    logic [7:0]  wr_ram_val;

    operating_hour_meter_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2ns aclk = ~aclk;

    // move pending hours into the total, clearing the backup byte if in use
    task automatic flush_pending();
        if (hm_pending != 8'd0) begin
            hm_total   = hm_total + {24'd0, hm_pending};
            hm_pending = 8'd0;
            if (cur_store) wr_total = 1'b1;
            if (hm_linked) begin
                wr_ram     = 1'b1;
                wr_ram_val = 8'd0;
            end
        end
    endtask

    // apply one command word to the meter copy and build its result word
    task automatic advance_meter(input logic [CMD_W-1:0] cmd, input in_word_t w,
                                 output out_word_t res);
        logic [23:0] span;
        logic [7:0]  byte_in;
        wr_ram     = 1'b0;
        wr_ram_val = 8'd0;
        wr_total   = 1'b0;
        wr_starts  = 1'b0;
        cur_store  = w.store_ok;
        case (cmd)
            CMD_TICK: begin
                // checks never come further apart than one hour
                span = (ivl_check < len_hour) ? ivl_check : len_hour;
                if (hm_since_check != CHECK_MAX) hm_since_check++;
                if (hm_since_base != BASE_MAX) hm_since_base++;
                if (hm_since_check >= span) begin
                    hm_since_check = '0;
                    if (!hm_linked) begin
                        // attach only when the chip answers and the byte reads back
                        if (w.rtc_present && w.rtc_ram_ok) begin
                            hm_linked = 1'b1;
                            byte_in   = w.rtc_ram_value;
                            // time lost or byte beyond the limit: throw it away
                            if (!w.rtc_time_valid || byte_in > lim_flush) begin
                                byte_in    = 8'd0;
                                wr_ram     = 1'b1;
                                wr_ram_val = 8'd0;
                            end
                            hm_pending    = byte_in;
                            hm_since_base = '0;
                            flush_pending();
                        end
                    end else if (hm_since_base >= len_hour) begin
                        // at most one hour per check, even if more are owed
                        hm_since_base = hm_since_base - len_hour;
                        if (hm_pending != PEND_MAX) hm_pending++;
                        wr_ram     = 1'b1;
                        wr_ram_val = hm_pending;
                        if (hm_pending >= lim_flush) flush_pending();
                    end
                end
            end
            CMD_START: begin
                if (w.store_ok) begin
                    hm_total  = w.stored_total;
                    hm_starts = w.stored_starts + 32'd1;
                    wr_starts = 1'b1;
                end
                hm_since_base  = '0;
                hm_since_check = '0;
            end
            CMD_CLEAR: begin
                hm_total       = '0;
                hm_pending     = '0;
                hm_starts      = '0;
                hm_since_base  = '0;
                hm_since_check = '0;
                if (w.store_ok) begin
                    wr_total  = 1'b1;
                    wr_starts = 1'b1;
                end
                // attachment survives the clear, the backup byte is zeroed
                if (hm_linked) begin
                    wr_ram     = 1'b1;
                    wr_ram_val = 8'd0;
                end
            end
            default: begin
            end
        endcase
        res = '0;
        res.total_hours        = hm_total;
        res.pending_hours      = hm_pending;
        res.start_count        = hm_starts;
        res.attached           = hm_linked;
        res.ram_write          = wr_ram;
        res.ram_value          = wr_ram_val;
        res.store_total_write  = wr_total;
        res.store_starts_write = wr_starts;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    function automatic meter_item_t mk_item(logic [CMD_W-1:0] cmd, logic [31:0] tot,
                                            logic [31:0] sts, logic ok, logic pres,
                                            logic rok, logic [7:0] rv, logic tv);
        meter_item_t it;
        it = '0;
        it.cmd                    = cmd;
        it.payload.stored_total   = tot;
        it.payload.stored_starts  = sts;
        it.payload.store_ok       = ok;
        it.payload.rtc_present    = pres;
        it.payload.rtc_ram_ok     = rok;
        it.payload.rtc_ram_value  = rv;
        it.payload.rtc_time_valid = tv;
        return it;
    endfunction

    // stored values lean toward the extremes now and then
    function automatic logic [31:0] draw_stored();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return 32'd0;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // mostly ticks with a healthy clock chip, some starts and clears
    function automatic meter_item_t draw_item(int start_pct, int clear_pct);
        int unsigned r;
        logic [CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < clear_pct) cmd = CMD_CLEAR;
        else if (r < clear_pct + start_pct) cmd = CMD_START;
        else cmd = CMD_TICK;
        return mk_item(cmd, draw_stored(), draw_stored(), $urandom_range(0, 4) != 0,
                       $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
                       8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
    endfunction

    task automatic queue_random(int count, int start_pct, int clear_pct);
        for (int i = 0; i < count; i++) cmd_backlog.push_back(draw_item(start_pct, clear_pct));
    endtask

    // wait until every word is in and every result is out
    task automatic settle();
        @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_FLUSH_LIMIT:    lim_flush = value[7:0];
            REG_CHECK_INTERVAL: ivl_check = value;
            REG_HOUR_LENGTH:    len_hour  = value;
            default: begin
            end
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_phase(input logic [7:0] fl, input logic [23:0] ci,
                             input logic [23:0] hl, input logic tx_on, input logic rx_on);
        settle();
        set_register(REG_FLUSH_LIMIT, {16'd0, fl});
        set_register(REG_CHECK_INTERVAL, ci);
        set_register(REG_HOUR_LENGTH, hl);
        tx_idle_on = tx_on;
        rx_idle_on = rx_on;
    endtask

    // sender: offers backlog words, predicts each one as it is taken
    always @(posedge aclk) begin : drive_words
        out_word_t   predicted;
        meter_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_meter(s_tuser, in_word_t'(s_tdata), predicted);
                expected_words.push_back(predicted);
                tx_gap = tx_idle_on ? int'($urandom_range(0, 17)) : 0;
            end else if (!s_tvalid && tx_gap > 0) begin
                tx_gap--;
            end
            // a word still waiting for ready stays on the bus untouched
            if (!s_tvalid || s_tready) begin
                if (tx_gap == 0 && cmd_backlog.size() != 0) begin
                    nxt = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.payload;
                    s_tuser  <= nxt.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold on request
    always @(posedge aclk) begin : take_results
        out_word_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap  = 0;
            rx_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_words.size() == 0) begin
                    $error("result word with no expected word waiting");
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    cmp_field("total_hours", want.total_hours, got.total_hours);
                    cmp_field("pending_hours", 32'(want.pending_hours),
                              32'(got.pending_hours));
                    cmp_field("start_count", want.start_count, got.start_count);
                    cmp_field("attached", 32'(want.attached), 32'(got.attached));
                    cmp_field("ram_write", 32'(want.ram_write), 32'(got.ram_write));
                    cmp_field("ram_value", 32'(want.ram_value), 32'(got.ram_value));
                    cmp_field("store_total_write", 32'(want.store_total_write),
                              32'(got.store_total_write));
                    cmp_field("store_starts_write", 32'(want.store_starts_write),
                              32'(got.store_starts_write));
                end
                rx_gap = rx_idle_on ? int'($urandom_range(0, 17)) : 0;
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            if (hold_req_seq != hold_req_seen) begin
                hold_req_seen = hold_req_seq;
                rx_hold = LONG_HOLD;
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_tready <= (rx_gap == 0) && (rx_hold == 0);
        end
    end

    // watchdog on cycles where neither side moves a word
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("operating_hour_meter_core verification failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: one check per tick, an hour every two ticks, flush at three
        set_phase(8'd3, 24'd1, 24'd2, 1'b1, 1'b1);
        cmd_backlog.push_back(mk_item(CMD_CLEAR, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0));
        // start without a store leaves the counts alone
        cmd_backlog.push_back(mk_item(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                                      1'b1, 1'b1, 8'hFF, 1'b1));
        // start count wraps, total sits just below the wrap
        cmd_backlog.push_back(mk_item(CMD_START, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1,
                                      1'b0, 1'b0, 8'h00, 1'b0));
        // chip missing, then byte read failing: no attach
        cmd_backlog.push_back(mk_item(CMD_TICK, 32'd0, 32'd0, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b1));
        cmd_backlog.push_back(mk_item(CMD_TICK, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 8'h02, 1'b1));
        // attach with a kept byte, flushed at once so the total wraps
        cmd_backlog.push_back(mk_item(CMD_TICK, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1, 8'h02, 1'b1));
        for (int i = 0; i < 8; i++)
            cmd_backlog.push_back(mk_item(CMD_TICK, 32'd0, 32'd0, logic'(i % 2),
                                          1'b1, 1'b1, 8'hAA, 1'b0));
        // clear while attached zeroes the backup byte
        cmd_backlog.push_back(mk_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                                      1'b1, 1'b1, 8'hFF, 1'b1));
        cmd_backlog.push_back(mk_item(CMD_START, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0));
        for (int i = 0; i < 6; i++)
            cmd_backlog.push_back(mk_item(CMD_TICK, 32'd0, 32'd0, 1'b1,
                                          1'b0, 1'b0, 8'h00, 1'b0));

        // smallest settings: an hour and a flush on every tick,
        // with a long receiver hold so the block backs up into the sender
        set_phase(8'd1, 24'd1, 24'd1, 1'b1, 1'b1);
        queue_random(250, 5, 3);
        hold_req_seq++;

        // largest flush limit, no clears so pending can climb, no idling
        set_phase(8'd255, 24'd1, 24'd3, 1'b0, 1'b0);
        queue_random(500, 2, 0);

        // lowered limit below what is pending: next hour flushes it all
        set_phase(8'd10, 24'd2, 24'd2, 1'b1, 1'b0);
        queue_random(200, 5, 3);

        // largest interval, clamped down to the hour length
        set_phase(8'd200, 24'hFF_FFFF, 24'd5, 1'b0, 1'b1);
        queue_random(200, 5, 3);

        // largest hour length: time piles up with no hour counted
        set_phase(8'd100, 24'd3, 24'hFF_FFFF, 1'b1, 1'b1);
        queue_random(250, 0, 0);

        // short hour after the pile-up: one hour per check, many still owed
        set_phase(8'd50, 24'd4, 24'd1, 1'b1, 1'b1);
        queue_random(200, 5, 3);

        // back to the power-up settings
        set_phase(FLUSH_LIMIT_RST, CHECK_INTERVAL_RST, HOUR_LENGTH_RST, 1'b1, 1'b1);
        queue_random(100, 5, 3);

        settle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("operating_hour_meter_core verification clean");
        end else begin
            $display("operating_hour_meter_core verification failed");
        end
        $finish;
    end

endmodule
